FILE: rtl/tic_pkg.sv
package tic_pkg;
  localparam int OUT_W = 24;
endpackage

FILE: rtl/tic_if.sv
interface tri_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
endinterface

interface ctr_if import tic_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic                    degenerate;
  modport source (output valid, center_x, center_y, degenerate, input ready);
  modport sink (input valid, center_x, center_y, degenerate, output ready);
endinterface

FILE: rtl/triangle_incenter_top.sv
// Triangle incenter, side-length weighted, fully pipelined.
// Input channel "in" carries one triangle per transaction (vertices A, B, C,
// signed COORD_BITS integers). Output channel "out" carries the incenter in
// signed fixed point with FRACTION_BITS fraction bits, truncated toward zero,
// plus a degenerate flag set when all vertices coincide (vertex A returned).
// Stages: 2 square stages + (COORD_BITS+FRACTION_BITS+2) square-root stages
// + 2 weighting stages + (2*COORD_BITS+2*FRACTION_BITS+4) divider stages
// + 1 output stage.
// Throughput: one triangle per cycle while not stalled; the root and divider
// units each retire one bit per stage, so their depth sets latency, not rate.
// The whole pipeline advances together; when the receiver holds ready low
// with a result waiting, every stage holds and in.ready drops, so nothing is
// lost or repeated. Reset clears all valid bits; data registers are not reset.
module triangle_incenter_top import tic_pkg::*; #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input logic  clk,
  input logic  rst,
  tri_if.sink  in,
  ctr_if.source out
);
  localparam int C   = COORD_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int LW  = C + F + 2;
  localparam int PW  = LW + 2;
  localparam int MW  = LW + C;
  localparam int N   = MW + 2 + F;
  localparam int QW  = C + F + 1;
  localparam int SQW = 2 * C + 4;
  localparam logic signed [63:0] BIAS = 64'sd1 <<< (C - 1 + F);

  logic adv;
  assign adv      = !out.valid || out.ready;
  assign in.ready = adv;

  // stage 1: squared differences
  logic           s1_vld;
  logic [2*C+1:0] s1_sx [3];
  logic [2*C+1:0] s1_sy [3];
  logic [6*C-1:0] s1_co;
  logic signed [C:0] dx [3];
  logic signed [C:0] dy [3];
  logic signed [2*C+1:0] px [3];
  logic signed [2*C+1:0] py [3];

  assign dx[0] = C'(in.c_x) - C'(in.b_x);
  assign dy[0] = C'(in.c_y) - C'(in.b_y);
  assign dx[1] = C'(in.a_x) - C'(in.c_x);
  assign dy[1] = C'(in.a_y) - C'(in.c_y);
  assign dx[2] = C'(in.b_x) - C'(in.a_x);
  assign dy[2] = C'(in.b_y) - C'(in.a_y);
  for (genvar j = 0; j < 3; j++) begin : g_sq
    assign px[j] = dx[j] * dx[j];
    assign py[j] = dy[j] * dy[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s1_sx[j] <= px[j];
        s1_sy[j] <= py[j];
      end
      s1_co <= {in.a_x, in.a_y, in.b_x, in.b_y, in.c_x, in.c_y};
    end
  end

  // stage 2: radicands
  logic           s2_vld;
  logic [SQW-1:0] s2_sq [3];
  logic [6*C-1:0] s2_co;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s2_sq[j] <= SQW'(s1_sx[j]) + SQW'(s1_sy[j]);
      end
      s2_co <= s1_co;
    end
  end

  logic           rt_vld;
  logic [LW-1:0]  rt [3];
  logic [6*C-1:0] rt_co;
  tic_sqrt3 #(.SQW(SQW), .LW(LW), .TOP(C + 1), .SBW(6 * C)) u_sqrt (
    .clk, .rst, .adv,
    .in_vld(s2_vld), .in_sq(s2_sq), .in_side(s2_co),
    .out_vld(rt_vld), .out_root(rt), .out_side(rt_co)
  );

  // weighting: coordinates offset to unsigned by flipping the sign bit
  logic [C-1:0] ux [3];
  logic [C-1:0] uy [3];
  assign ux[0] = rt_co[6*C-1 -: C] ^ (C'(1) << (C - 1));
  assign uy[0] = rt_co[5*C-1 -: C] ^ (C'(1) << (C - 1));
  assign ux[1] = rt_co[4*C-1 -: C] ^ (C'(1) << (C - 1));
  assign uy[1] = rt_co[3*C-1 -: C] ^ (C'(1) << (C - 1));
  assign ux[2] = rt_co[2*C-1 -: C] ^ (C'(1) << (C - 1));
  assign uy[2] = rt_co[C-1 -: C]   ^ (C'(1) << (C - 1));

  logic           m_vld;
  logic [MW-1:0]  m_px [3];
  logic [MW-1:0]  m_py [3];
  logic [PW-1:0]  m_p;
  logic [2*C-1:0] m_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= rt_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        m_px[j] <= MW'(rt[j]) * MW'(ux[j]);
        m_py[j] <= MW'(rt[j]) * MW'(uy[j]);
      end
      m_p <= PW'(rt[0]) + PW'(rt[1]) + PW'(rt[2]);
      m_a <= rt_co[6*C-1 -: 2*C];
    end
  end

  logic           a_vld;
  logic [N-1:0]   a_acc [2];
  logic [PW-1:0]  a_p;
  logic [2*C-1:0] a_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= m_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_acc[0] <= (N'(m_px[0]) + N'(m_px[1]) + N'(m_px[2])) << F;
      a_acc[1] <= (N'(m_py[0]) + N'(m_py[1]) + N'(m_py[2])) << F;
      a_p      <= m_p;
      a_a      <= m_a;
    end
  end

  logic           d_vld;
  logic [QW-1:0]  d_q [2];
  logic           d_rnz [2];
  logic [PW-1:0]  d_p;
  logic [2*C-1:0] d_a;
  tic_div2 #(.N(N), .PW(PW), .QW(QW), .SBW(2 * C)) u_div (
    .clk, .rst, .adv,
    .in_vld(a_vld), .in_acc(a_acc), .in_p(a_p), .in_side(a_a),
    .out_vld(d_vld), .out_q(d_q), .out_rnz(d_rnz), .out_p(d_p), .out_side(d_a)
  );

  // undo the offset, truncate toward zero, or return vertex A
  logic signed [63:0] sv [2];
  logic signed [63:0] av [2];
  logic               deg;
  assign deg   = d_p == '0;
  assign av[0] = 64'($signed(d_a[2*C-1 -: C])) <<< F;
  assign av[1] = 64'($signed(d_a[C-1 -: C])) <<< F;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sv[l] = $signed(64'(d_q[l])) - BIAS;
      if (sv[l] < 0 && d_rnz[l]) sv[l] = sv[l] + 64'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (adv) begin
      out.valid <= d_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out.center_x   <= deg ? av[0][OUT_W-1:0] : sv[0][OUT_W-1:0];
      out.center_y   <= deg ? av[1][OUT_W-1:0] : sv[1][OUT_W-1:0];
      out.degenerate <= deg;
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in.ready == (!out.valid || out.ready))
    else $error("input ready does not follow pipeline advance");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out.valid)
    else $error("result valid right after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.center_x))
    else $error("stalled pipeline did not hold");
endmodule

FILE: rtl/tic_sqrt3.sv
// Three-lane digit-by-digit square root, one result bit per stage.
module tic_sqrt3 #(
  parameter int SQW = 36,
  parameter int LW  = 26,
  parameter int TOP = 17,
  parameter int SBW = 96
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [SQW-1:0] in_sq [3],
  input  logic [SBW-1:0] in_side,
  output logic           out_vld,
  output logic [LW-1:0]  out_root [3],
  output logic [SBW-1:0] out_side
);
  localparam int S  = LW;
  localparam int RW = LW + 3;

  logic [SQW-1:0] sq   [0:S][3];
  logic [RW-1:0]  rem  [0:S][3];
  logic [LW-1:0]  root [0:S][3];
  logic           vld  [0:S];
  logic [SBW-1:0] side [0:S];

  assign vld[0]  = in_vld;
  assign side[0] = in_side;
  for (genvar l = 0; l < 3; l++) begin : g_in
    assign sq[0][l]   = in_sq[l];
    assign rem[0][l]  = '0;
    assign root[0][l] = '0;
    assign out_root[l] = root[S][l];
  end
  assign out_vld  = vld[S];
  assign out_side = side[S];

  for (genvar k = 0; k < S; k++) begin : g_st
    localparam int I = TOP - k;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) side[k+1] <= side[k];
    end
    for (genvar l = 0; l < 3; l++) begin : g_ln
      logic [1:0]    pair;
      logic [RW-1:0] rsh;
      logic [RW-1:0] trial;
      logic          fit;
      if (I >= 0) begin : g_pair
        assign pair = sq[k][l][2*I+1 -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end
      assign rsh   = {rem[k][l][RW-3:0], pair};
      assign trial = {1'b0, root[k][l], 2'b01};
      assign fit   = rsh >= trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          sq[k+1][l]   <= sq[k][l];
          rem[k+1][l]  <= fit ? (rsh - trial) : rsh;
          root[k+1][l] <= {root[k][l][LW-2:0], fit};
        end
      end
    end
  end
endmodule

FILE: rtl/tic_div2.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per stage.
module tic_div2 #(
  parameter int N   = 52,
  parameter int PW  = 28,
  parameter int QW  = 25,
  parameter int SBW = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [N-1:0]   in_acc [2],
  input  logic [PW-1:0]  in_p,
  input  logic [SBW-1:0] in_side,
  output logic           out_vld,
  output logic [QW-1:0]  out_q [2],
  output logic           out_rnz [2],
  output logic [PW-1:0]  out_p,
  output logic [SBW-1:0] out_side
);
  logic [N-1:0]   acc  [0:N][2];
  logic [PW-1:0]  r    [0:N][2];
  logic [QW-1:0]  q    [0:N][2];
  logic [PW-1:0]  p    [0:N];
  logic           vld  [0:N];
  logic [SBW-1:0] side [0:N];

  assign vld[0]  = in_vld;
  assign side[0] = in_side;
  assign p[0]    = in_p;
  for (genvar l = 0; l < 2; l++) begin : g_in
    assign acc[0][l] = in_acc[l];
    assign r[0][l]   = '0;
    assign q[0][l]   = '0;
    assign out_q[l]   = q[N][l];
    assign out_rnz[l] = r[N][l] != '0;
  end
  assign out_vld  = vld[N];
  assign out_p    = p[N];
  assign out_side = side[N];

  for (genvar k = 0; k < N; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        side[k+1] <= side[k];
        p[k+1]    <= p[k];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_ln
      logic [PW:0] rsh;
      logic [PW:0] diff;
      logic        fit;
      assign rsh  = {r[k][l], acc[k][l][N-1-k]};
      assign diff = rsh - {1'b0, p[k]};
      assign fit  = rsh >= {1'b0, p[k]};
      always_ff @(posedge clk) begin
        if (adv) begin
          acc[k+1][l] <= acc[k][l];
          r[k+1][l]   <= fit ? diff[PW-1:0] : rsh[PW-1:0];
          q[k+1][l]   <= {q[k][l][QW-2:0], fit};
        end
      end
    end
  end
endmodule

FILE: dv/tb_triangle_incenter_top.sv
module tb_triangle_incenter_top import tic_pkg::*; ();

  localparam int CB = 16;
  localparam int FB = 8;
  localparam int LATENCY = 83;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic signed [CB-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  } tri_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic                    degen;
  } ctr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tri_if #(.COORD_BITS(CB)) in_ch ();
  ctr_if out_ch ();

  triangle_incenter_top #(.COORD_BITS(CB), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  always #2 clk = ~clk;

  tri_t pending_tris[$];
  ctr_t expected_centers[$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   cycle_count = 0;
  bit   stim_done = 1'b0;
  bit   no_idle = 1'b0;
  bit   in_fire = 1'b0;

  // floor(sqrt(dx^2+dy^2) * 2^FB), digit by digit
  function automatic longint unsigned side_length(longint dx, longint dy);
    longint unsigned sq, root, rem, trial, pair;
    sq = longint'(dx * dx) + longint'(dy * dy);
    root = 0;
    rem = 0;
    for (int i = CB + 1; i >= -FB; i--) begin
      pair = (i >= 0) ? ((sq >> (2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] axis_center(
      longint unsigned wa, longint ca, longint unsigned wb, longint cb_,
      longint unsigned wc, longint cc, longint unsigned per);
    logic signed [159:0] num, q, r;
    logic signed [159:0] off;
    off = 160'sd1 <<< (CB - 1);
    num = $signed({96'd0, wa}) * (ca + off) + $signed({96'd0, wb}) * (cb_ + off)
        + $signed({96'd0, wc}) * (cc + off);
    num = num <<< FB;
    q = num / $signed({96'd0, per});
    r = num % $signed({96'd0, per});
    q = q - (off <<< FB);
    if (q < 0 && r != 0) q = q + 1;
    return q[OUT_W-1:0];
  endfunction

  function automatic ctr_t predict_center(tri_t t);
    ctr_t e;
    longint ax, ay, bx, by, cx, cy;
    longint unsigned lbc, lca, lab, per;
    ax = t.a_x; ay = t.a_y; bx = t.b_x; by = t.b_y; cx = t.c_x; cy = t.c_y;
    lbc = side_length(cx - bx, cy - by);
    lca = side_length(ax - cx, ay - cy);
    lab = side_length(bx - ax, by - ay);
    per = lbc + lca + lab;
    if (per == 0) begin
      e.cx = OUT_W'(ax <<< FB);
      e.cy = OUT_W'(ay <<< FB);
      e.degen = 1'b1;
    end else begin
      e.cx = axis_center(lbc, ax, lca, bx, lab, cx, per);
      e.cy = axis_center(lbc, ay, lca, by, lab, cy, per);
      e.degen = 1'b0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return CB'($signed($urandom_range(0, 40)) - 20);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.a_x = rand_coord(); t.a_y = rand_coord();
    t.b_x = rand_coord(); t.b_y = rand_coord();
    t.c_x = rand_coord(); t.c_y = rand_coord();
    case ($urandom_range(0, 9))
      0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.c_x = t.a_x; t.c_y = t.a_y; end
      1: begin t.b_x = t.a_x; t.b_y = t.a_y; end
      2: begin t.c_x = t.b_x; t.c_y = t.b_y; end
      3: begin
        // small triangle: B and C at fixed offsets from A
        t.b_x = CB'(t.a_x + 3); t.b_y = CB'(t.a_y + 5);
        t.c_x = CB'(t.a_x - 7); t.c_y = CB'(t.a_y - 11);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy);
    tri_t t;
    t.a_x = CB'(ax); t.a_y = CB'(ay); t.b_x = CB'(bx);
    t.b_y = CB'(by); t.c_x = CB'(cx); t.c_y = CB'(cy);
    return t;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y, in_ch.c_x, in_ch.c_y} <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 27);
      // advance only when the last transaction was taken at the rising edge
      if (!in_ch.valid || in_fire) begin
        if (pending_tris.size() != 0 && (no_idle || $urandom_range(0, 99) >= 27)) begin
          {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y, in_ch.c_x, in_ch.c_y}
            <= pending_tris.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ctr_t want;
    tri_t t;
    in_fire = in_ch.valid && in_ch.ready;
    if (!rst) begin
      cycle_count++;
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        t = {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y, in_ch.c_x, in_ch.c_y};
        expected_centers.push_back(predict_center(t));
        idle_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (expected_centers.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = expected_centers.pop_front();
          if (out_ch.center_x !== want.cx) report_mismatch("center_x", out_ch.center_x, want.cx);
          if (out_ch.center_y !== want.cy) report_mismatch("center_y", out_ch.center_y, want.cy);
          if (out_ch.degenerate !== want.degen)
            report_mismatch("degenerate", out_ch.degenerate, want.degen);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_triangle_incenter_top failed");
        $finish;
      end
    end
  end

  initial begin
    pending_tris.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_tris.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_tris.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
    pending_tris.push_back(mk(-5, 9, -5, 9, -5, 9));
    pending_tris.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767));
    pending_tris.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767));
    pending_tris.push_back(mk(-32768, 0, 32767, 0, 0, 32767));
    pending_tris.push_back(mk(0, 0, 3, 0, 0, 4));
    pending_tris.push_back(mk(0, 0, 1, 1, 2, 2));
    pending_tris.push_back(mk(-32768, -32768, 0, 0, 32767, 32767));
    pending_tris.push_back(mk(1, 1, 1, 1, 2, 3));
    pending_tris.push_back(mk(4, 4, -7, 2, -7, 2));
    pending_tris.push_back(mk(-1, -1, 0, 0, 1, -1));
    pending_tris.push_back(mk(-32768, 32767, -32768, -32768, 32767, -32768));
    pending_tris.push_back(mk(-3, -3, -3, -2, -2, -3));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_RANDOM; i++) pending_tris.push_back(rand_tri());
    wait (pending_tris.size() == 0);
    @(posedge clk);
    // back-to-back stretch with no idling on either side
    no_idle = 1'b1;
    for (int i = 0; i < 200; i++) pending_tris.push_back(rand_tri());
    wait (pending_tris.size() == 0);
    no_idle = 1'b0;
    wait (pending_tris.size() == 0 && !in_ch.valid);
    wait (expected_centers.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_centers.size() == 0) begin
      $display("tb_triangle_incenter_top passed");
    end else begin
      $display("tb_triangle_incenter_top failed");
    end
    $finish;
  end
endmodule
